>>> src/krb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krb_pkg: shared constants and a helper for the keyed rectangle blitter
// Widths, register indexes, mode bits and the source side clamp.
// ----------------------------------------------------------------------------
package krb_pkg;

    // Largest source rectangle side and derived counter width
    localparam int MAX_SIDE = 512;
    localparam int CNT_W    = $clog2(MAX_SIDE);

    // Fixed field widths
    localparam int REG_W  = 10;
    localparam int POS_W  = 9;
    localparam int KEY_W  = 8;
    localparam int PIX_W  = 32;
    localparam int ADDR_W = 18;
    localparam int MODE_W = 2;
    localparam int IDX_W  = 3;

    // Clamped side must hold MAX_SIDE and any 10-bit register value
    localparam int SIDE_W = (CNT_W + 1 > REG_W) ? CNT_W + 1 : REG_W;
    // Destination coordinate: position plus counter, one carry bit
    localparam int DXY_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    // Fit check sum: position plus side
    localparam int FIT_W  = SIDE_W + 1;

    // Stream widths
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 64;
    localparam int M_USER_W = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DEST_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_DEST_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SRC_WIDTH   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_POS_X       = 3'd4;
    localparam logic [IDX_W-1:0] CFG_POS_Y       = 3'd5;
    localparam logic [IDX_W-1:0] CFG_KEY_REF     = 3'd6;
    localparam logic [IDX_W-1:0] CFG_MODE        = 3'd7;

    // Mode bit positions
    localparam int MODE_TRANSPOSE = 0;
    localparam int MODE_MARKER    = 1;

    // tuser bit positions on the result channel
    localparam int USER_WE  = 0;
    localparam int USER_FIT = 1;

    // Source side as used: zero reads as one, oversize reads as MAX_SIDE
    function automatic logic [SIDE_W-1:0] eff_side(input logic [REG_W-1:0] v);
        logic [SIDE_W-1:0] ext;
        ext = SIDE_W'(v);
        if (ext == '0) begin
            return SIDE_W'(1);
        end else if (ext > SIDE_W'(MAX_SIDE)) begin
            return SIDE_W'(MAX_SIDE);
        end
        return ext;
    endfunction

endpackage
`default_nettype wire

>>> src/keyed_rect_blit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_rect_blit: keyed 2D rectangle copy with optional transpose
// Counts source pixels in row-major order and emits, per pixel, the
// destination address, the keyed write enable and a fit-error flag.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock while the result side is not stalled and
// returns one result per pixel. The first stage registers the pixel with its
// destination column and row taken from the column/row counters; the second
// stage forms dy*dest_width+dx with a single 18-bit multiply-add, the fit
// check and the key compare. A finished result waits in the output register
// while the next pixel is taken, so full throughput holds as long as
// m_tready stays high. Configuration is written through cfg_we / cfg_index /
// cfg_wdata and must only change while no pixel is in flight; the counters
// are not cleared by configuration writes.
module keyed_rect_blit (
    input  wire                         aclk,
    input  wire                         aresetn,
    // configuration write port
    input  wire                         cfg_we,
    input  wire [krb_pkg::IDX_W-1:0]    cfg_index,
    input  wire [krb_pkg::REG_W-1:0]    cfg_wdata,
    // source pixels
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire [krb_pkg::S_DATA_W-1:0] s_tdata,   // pixel[31:0], marker[39:32]
    // destination writes
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [krb_pkg::M_DATA_W-1:0] m_tdata,  // dest_addr[17:0],
                                                   // pixel_out[49:18],
                                                   // marker_out[57:50], zero
    output logic [krb_pkg::M_USER_W-1:0] m_tuser,  // write_enable[0],
                                                   // fit_error[1]
    output logic                        m_tlast
);
    import krb_pkg::*;

    // Configuration registers
    logic [REG_W-1:0]  dest_width_reg, dest_height_reg;
    logic [REG_W-1:0]  src_width_reg, src_height_reg;
    logic [POS_W-1:0]  pos_x_reg, pos_y_reg;
    logic [KEY_W-1:0]  key_ref_reg;
    logic [MODE_W-1:0] mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_width_reg  <= REG_W'(512);
            dest_height_reg <= REG_W'(512);
            src_width_reg   <= REG_W'(1);
            src_height_reg  <= REG_W'(1);
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            key_ref_reg     <= '0;
            mode_reg        <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DEST_WIDTH:  dest_width_reg  <= cfg_wdata;
                CFG_DEST_HEIGHT: dest_height_reg <= cfg_wdata;
                CFG_SRC_WIDTH:   src_width_reg   <= cfg_wdata;
                CFG_SRC_HEIGHT:  src_height_reg  <= cfg_wdata;
                CFG_POS_X:       pos_x_reg       <= cfg_wdata[POS_W-1:0];
                CFG_POS_Y:       pos_y_reg       <= cfg_wdata[POS_W-1:0];
                CFG_KEY_REF:     key_ref_reg     <= cfg_wdata[KEY_W-1:0];
                CFG_MODE:        mode_reg        <= cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    logic transpose, marker_mode;
    logic [SIDE_W-1:0] side_w, side_h;
    assign transpose   = mode_reg[MODE_TRANSPOSE];
    assign marker_mode = mode_reg[MODE_MARKER];
    assign side_w      = eff_side(src_width_reg);
    assign side_h      = eff_side(src_height_reg);

    // Handshake: stage 1 moves on when the output register is free
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic out_free, s_xfer, s1_adv;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_xfer   = s_tvalid && s_tready;

    // Column/row counters, advance on each input transfer
    logic [CNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic col_end, row_end;

    assign col_end = SIDE_W'(col_cnt_reg) >= side_w - SIDE_W'(1);
    assign row_end = SIDE_W'(row_cnt_reg) >= side_h - SIDE_W'(1);

    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (s_xfer) begin
            if (col_end) begin
                col_cnt_next = '0;
                row_cnt_next = row_end ? '0 : row_cnt_reg + CNT_W'(1);
            end else begin
                col_cnt_next = col_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Destination coordinates for the pixel being taken
    logic [DXY_W-1:0] dx_next, dy_next;
    always_comb begin
        if (transpose) begin
            dx_next = DXY_W'(pos_x_reg) + DXY_W'(row_cnt_reg);
            dy_next = DXY_W'(pos_y_reg) + DXY_W'(col_cnt_reg);
        end else begin
            dx_next = DXY_W'(pos_x_reg) + DXY_W'(col_cnt_reg);
            dy_next = DXY_W'(pos_y_reg) + DXY_W'(row_cnt_reg);
        end
    end

    // Stage 1 payload
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [KEY_W-1:0] s1_marker_reg;
    logic [DXY_W-1:0] s1_dx_reg, s1_dy_reg;
    logic             s1_last_reg;

    always_comb begin
        if (s_xfer) begin
            s1_valid_next = 1'b1;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        m_valid_next = out_free ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_pixel_reg  <= s_tdata[PIX_W-1:0];
            s1_marker_reg <= s_tdata[PIX_W +: KEY_W];
            s1_dx_reg     <= dx_next;
            s1_dy_reg     <= dy_next;
            s1_last_reg   <= col_end && row_end;
        end
    end

    // Stage 2: address multiply-add, fit check and key compare
    logic [ADDR_W-1:0] addr_next;
    logic              fit_err_next, we_next;
    logic [KEY_W-1:0]  key, marker_out_next;
    logic [FIT_W-1:0]  span_x, span_y;

    assign addr_next = ADDR_W'(s1_dy_reg) * ADDR_W'(dest_width_reg) + ADDR_W'(s1_dx_reg);

    assign span_x = FIT_W'(pos_x_reg) + FIT_W'(transpose ? side_h : side_w);
    assign span_y = FIT_W'(pos_y_reg) + FIT_W'(transpose ? side_w : side_h);
    assign fit_err_next = (span_x > FIT_W'(dest_width_reg))
                       || (span_y > FIT_W'(dest_height_reg));

    assign key             = marker_mode ? s1_marker_reg : s1_pixel_reg[PIX_W-1 -: KEY_W];
    assign we_next         = (key >= key_ref_reg) && !fit_err_next;
    assign marker_out_next = marker_mode ? s1_marker_reg : '0;

    // Output register
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_USER_W-1:0] m_user_reg;
    logic                m_last_reg;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= M_DATA_W'({marker_out_next, s1_pixel_reg, addr_next});
            m_user_reg[USER_WE]  <= we_next;
            m_user_reg[USER_FIT] <= fit_err_next;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

>>> src/krb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krb_checker: port-level checks for keyed_rect_blit
// Watches the stream ports and flags protocol or result inconsistencies.
// ----------------------------------------------------------------------------
module krb_checker (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    input  wire                          s_tready,
    input  wire                          m_tvalid,
    input  wire                          m_tready,
    input  wire [krb_pkg::M_DATA_W-1:0]  m_tdata,
    input  wire [krb_pkg::M_USER_W-1:0]  m_tuser,
    input  wire                          m_tlast
);
    import krb_pkg::*;

    // No result is presented right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result keeps its valid
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its contents
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // A misfit rectangle never produces a write
    a_no_write_on_misfit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_FIT] |-> !m_tuser[USER_WE])
        else $error("write enabled on fit error");

    // Input is always taken when the output side has room and nothing waits
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
        else $error("input stalled with empty pipeline");

endmodule

bind keyed_rect_blit krb_checker u_krb_checker (.*);
`default_nettype wire
